// ===== sv/ipc_pkg.sv =====
`timescale 1ns / 1ps

package ipc_pkg;

  localparam int NumPieces = 8;
  localparam int IdxW = $clog2(NumPieces);
  localparam int PieceW = 16;
  localparam int CharW = 7;

  localparam logic [CharW-1:0] CharColon = 7'h3a;
  localparam logic [CharW-1:0] CharZero = 7'h30;
  localparam logic [CharW-1:0] CharLowA = 7'h61;

  typedef logic [PieceW-1:0] piece_t;

  typedef struct packed {
    logic       is_zero;
    logic [1:0] ndig_m1;
  } lane_info_t;

  typedef struct packed {
    logic [NumPieces-1:0][PieceW-1:0] pieces;
    logic [NumPieces-1:0][1:0]        ndig_m1;
    logic                             has_run;
    logic [IdxW-1:0]                  run_start;
    logic [IdxW:0]                    run_end;
  } plan_t;

  typedef enum logic [2:0] {
    EM_IDLE,
    EM_LEAD,
    EM_RUN,
    EM_DIGIT,
    EM_SEP
  } emit_state_t;

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] res;
    if (nib < 4'd10) begin
      res = CharZero + {3'b000, nib};
    end else begin
      res = CharLowA + {3'b000, nib} - 7'd10;
    end
    return res;
  endfunction

endpackage

// ===== sv/ipc_in_if.sv =====
`timescale 1ns / 1ps

interface ipc_in_if;
  logic            valid;
  logic            ready;
  ipc_pkg::piece_t piece_0;
  ipc_pkg::piece_t piece_1;
  ipc_pkg::piece_t piece_2;
  ipc_pkg::piece_t piece_3;
  ipc_pkg::piece_t piece_4;
  ipc_pkg::piece_t piece_5;
  ipc_pkg::piece_t piece_6;
  ipc_pkg::piece_t piece_7;

  modport source (
    output valid, piece_0, piece_1, piece_2, piece_3,
    output piece_4, piece_5, piece_6, piece_7,
    input  ready
  );
  modport sink (
    input  valid, piece_0, piece_1, piece_2, piece_3,
    input  piece_4, piece_5, piece_6, piece_7,
    output ready
  );
endinterface

// ===== sv/ipc_out_if.sv =====
`timescale 1ns / 1ps

interface ipc_out_if;
  logic                        valid;
  logic                        ready;
  logic [ipc_pkg::CharW-1:0]   text_char;
  logic                        last_of_text;

  modport source (output valid, text_char, last_of_text, input ready);
  modport sink (input valid, text_char, last_of_text, output ready);
endinterface

// ===== sv/ipc_lane.sv =====
`timescale 1ns / 1ps

module ipc_lane (
  input  ipc_pkg::piece_t     piece,
  output ipc_pkg::lane_info_t info
);

  always_comb begin
    info.is_zero = (piece == '0);
    priority if (piece[15:12] != 4'h0) begin
      info.ndig_m1 = 2'd3;
    end else if (piece[11:8] != 4'h0) begin
      info.ndig_m1 = 2'd2;
    end else if (piece[7:4] != 4'h0) begin
      info.ndig_m1 = 2'd1;
    end else begin
      info.ndig_m1 = 2'd0;
    end
  end

endmodule

// ===== sv/ipc_merge.sv =====
`timescale 1ns / 1ps

module ipc_merge (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic [ipc_pkg::NumPieces-1:0][ipc_pkg::PieceW-1:0] in_pieces,
  output logic                                         plan_valid,
  input  logic                                         plan_take,
  output ipc_pkg::plan_t                               plan
);

  ipc_pkg::lane_info_t [ipc_pkg::NumPieces-1:0] info;
  ipc_pkg::plan_t                               plan_next;

  for (genvar g = 0; g < ipc_pkg::NumPieces; g++) begin : g_lane
    ipc_lane u_lane (
      .piece (in_pieces[g]),
      .info  (info[g])
    );
  end

  // first longest run of zero pieces
  always_comb begin
    logic [ipc_pkg::IdxW:0]   run_len;
    logic [ipc_pkg::IdxW-1:0] run_start;
    logic [ipc_pkg::IdxW:0]   best_len;
    logic [ipc_pkg::IdxW-1:0] best_start;
    run_len    = '0;
    run_start  = '0;
    best_len   = '0;
    best_start = '0;
    for (int i = 0; i < ipc_pkg::NumPieces; i++) begin
      if (info[i].is_zero) begin
        if (run_len == '0) begin
          run_start = ipc_pkg::IdxW'(i);
        end
        run_len = run_len + 1'b1;
        if (run_len > best_len) begin
          best_len   = run_len;
          best_start = run_start;
        end
      end else begin
        run_len = '0;
      end
    end
    plan_next.pieces    = in_pieces;
    for (int i = 0; i < ipc_pkg::NumPieces; i++) begin
      plan_next.ndig_m1[i] = info[i].ndig_m1;
    end
    plan_next.has_run   = (best_len >= (ipc_pkg::IdxW+1)'(2));
    plan_next.run_start = best_start;
    plan_next.run_end   = {1'b0, best_start} + best_len;
  end

  assign in_ready = !plan_valid || plan_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      plan_valid <= 1'b0;
    end else if (in_ready) begin
      plan_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      plan <= plan_next;
    end
  end

endmodule

// ===== sv/ipc_emit.sv =====
`timescale 1ns / 1ps

module ipc_emit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  plan_valid,
  output logic                  plan_take,
  input  ipc_pkg::plan_t        plan,
  ipc_out_if.source             text
);

  ipc_pkg::emit_state_t      state, state_next;
  ipc_pkg::plan_t            cur;
  logic [ipc_pkg::IdxW-1:0]  idx, idx_next;
  logic [1:0]                dig, dig_next;
  logic                      load;
  logic                      advance;
  logic                      step;
  logic [ipc_pkg::CharW-1:0] ch;
  logic                      is_last;
  logic [ipc_pkg::PieceW-1:0] cur_piece;
  logic [ipc_pkg::IdxW-1:0]  nxt_idx;

  assign advance   = !text.valid || text.ready;
  assign step      = advance && (state != ipc_pkg::EM_IDLE);
  assign cur_piece = cur.pieces[idx];
  assign nxt_idx   = idx + 1'b1;

  // outputs of the sequencer
  always_comb begin
    ch      = ipc_pkg::CharColon;
    is_last = 1'b0;
    unique case (state)
      ipc_pkg::EM_IDLE: begin
        ch = ipc_pkg::CharColon;
      end
      ipc_pkg::EM_LEAD, ipc_pkg::EM_SEP: begin
        ch = ipc_pkg::CharColon;
      end
      ipc_pkg::EM_RUN: begin
        ch      = ipc_pkg::CharColon;
        is_last = cur.run_end[ipc_pkg::IdxW];
      end
      ipc_pkg::EM_DIGIT: begin
        ch      = ipc_pkg::hex_char(cur_piece[{dig, 2'b00} +: 4]);
        is_last = (dig == 2'd0) && (idx == ipc_pkg::IdxW'(ipc_pkg::NumPieces - 1));
      end
    endcase
  end

  assign load      = (state == ipc_pkg::EM_IDLE) || (step && is_last);
  assign plan_take = load;

  // next state
  always_comb begin
    state_next = state;
    idx_next   = idx;
    dig_next   = dig;
    if (load) begin
      if (plan_valid) begin
        idx_next = '0;
        dig_next = plan.ndig_m1[0];
        if (plan.has_run && (plan.run_start == '0)) begin
          state_next = ipc_pkg::EM_LEAD;
        end else begin
          state_next = ipc_pkg::EM_DIGIT;
        end
      end else begin
        state_next = ipc_pkg::EM_IDLE;
      end
    end else if (step) begin
      unique case (state)
        ipc_pkg::EM_IDLE: begin
          state_next = ipc_pkg::EM_IDLE;
        end
        ipc_pkg::EM_LEAD: begin
          state_next = ipc_pkg::EM_RUN;
        end
        ipc_pkg::EM_RUN: begin
          // run does not reach the end, go on with the piece after it
          state_next = ipc_pkg::EM_DIGIT;
          idx_next   = cur.run_end[ipc_pkg::IdxW-1:0];
          dig_next   = cur.ndig_m1[cur.run_end[ipc_pkg::IdxW-1:0]];
        end
        ipc_pkg::EM_DIGIT: begin
          if (dig != 2'd0) begin
            dig_next = dig - 1'b1;
          end else begin
            state_next = ipc_pkg::EM_SEP;
          end
        end
        ipc_pkg::EM_SEP: begin
          idx_next = nxt_idx;
          if (cur.has_run && (nxt_idx == cur.run_start)) begin
            state_next = ipc_pkg::EM_RUN;
          end else begin
            state_next = ipc_pkg::EM_DIGIT;
            dig_next   = cur.ndig_m1[nxt_idx];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipc_pkg::EM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    dig <= dig_next;
    if (load && plan_valid) begin
      cur <= plan;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      text.valid <= 1'b0;
    end else if (advance) begin
      text.valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      text.text_char    <= ch;
      text.last_of_text <= is_last;
    end
  end

endmodule

// ===== sv/ipv6_compressed_text.sv =====
`timescale 1ns / 1ps

// Serializes one IPv6 address, given as eight 16-bit pieces, into its
// compressed text form, one ASCII word per cycle while text.ready does not
// stall it, with the final word marked. Eight lanes size the pieces in
// parallel, a merge stage picks the first longest zero run and registers the
// plan, and an emit sequencer walks the plan. An address's text is 2 to 39
// words long; the next address waits in the plan register and follows without
// a gap. From idle, an accepted address passes through the plan register and
// the sequencer state register before its first word leaves the output register.
module ipv6_compressed_text (
  input  logic      clk,
  input  logic      rst,
  ipc_in_if.sink    addr,
  ipc_out_if.source text
);

  logic                                              plan_valid;
  logic                                              plan_take;
  ipc_pkg::plan_t                                    plan;
  logic [ipc_pkg::NumPieces-1:0][ipc_pkg::PieceW-1:0] pieces;

  assign pieces[0] = addr.piece_0;
  assign pieces[1] = addr.piece_1;
  assign pieces[2] = addr.piece_2;
  assign pieces[3] = addr.piece_3;
  assign pieces[4] = addr.piece_4;
  assign pieces[5] = addr.piece_5;
  assign pieces[6] = addr.piece_6;
  assign pieces[7] = addr.piece_7;

  ipc_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (addr.valid),
    .in_ready   (addr.ready),
    .in_pieces  (pieces),
    .plan_valid (plan_valid),
    .plan_take  (plan_take),
    .plan       (plan)
  );

  ipc_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .plan_valid (plan_valid),
    .plan_take  (plan_take),
    .plan       (plan),
    .text       (text)
  );

endmodule

// ===== sv/ipc_checker.sv =====
`timescale 1ns / 1ps

module ipc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [ipc_pkg::CharW-1:0] out_char,
  input logic                      out_last
);

  // only hex digits and colons ever leave the block
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_char >= 7'h30) && (out_char <= 7'h39)) ||
                  ((out_char >= 7'h61) && (out_char <= 7'h66)) ||
                  (out_char == ipc_pkg::CharColon))
    else $error("illegal text word");

  // a stalled word holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_char) && $stable(out_last)))
    else $error("stalled word changed");

  // after reset nothing is pending and an address can be taken
  assert property (@(posedge clk) rst |=> (!out_valid && in_ready))
    else $error("state not cleared by reset");

  // a text ending in a single digit after a colon is fine, but a text never
  // ends right after reset came out on the same word
  assert property (@(posedge clk) disable iff (rst)
    ($fell(rst) ##1 out_valid) |-> !out_last)
    else $error("text ended too early");

endmodule

bind ipv6_compressed_text ipc_checker u_ipc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (addr.ready),
  .out_valid (text.valid),
  .out_ready (text.ready),
  .out_char  (text.text_char),
  .out_last  (text.last_of_text)
);
